// ----- src/trrd_pkg.sv -----
// shared types, constants and command format for the tilemap register run decoder
package trrd_pkg;

    localparam int GROUP_WORDS    = 8;
    localparam int SLOT_COUNT     = 8;
    localparam int REGISTER_COUNT = 4;
    localparam int MAX_RESULTS    = 36;
    localparam int HEADER_BYTES   = 4;
    localparam int LONG_RUN_BIAS  = 31;
    localparam int QUEUE_DEPTH    = 2;

    localparam int WORD_W    = 16;
    localparam int COUNT_W   = 24;
    localparam int LEN_W     = 9;
    localparam int REG_IDX_W = $clog2(REGISTER_COUNT);
    localparam int HDR_W     = $clog2(HEADER_BYTES + 1);
    localparam int GRP_W     = $clog2(MAX_RESULTS + 1);
    localparam int WCNT_W    = 4;
    localparam int QUEUE_AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // opcode kinds in bits 7:6
    localparam logic [1:0] KIND_XOR  = 2'b00;
    localparam logic [1:0] KIND_DOWN = 2'b01;
    localparam logic [1:0] KIND_RUN  = 2'b10;
    localparam logic [1:0] KIND_UP   = 2'b11;

    localparam logic [3:0] LEN_ESCAPE = 4'hF;

    typedef enum logic [3:0] {
        PH_OPCODE = 4'b0001,
        PH_HIGH   = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_LENGTH = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_XOR  = 2'd1,
        OP_RUN  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } t_step;

    typedef struct packed {
        t_op                  op;
        logic [REG_IDX_W-1:0] src;
        logic [REG_IDX_W-1:0] dst;
        logic [WORD_W-1:0]    operand;
        t_step                step;
        logic [LEN_W-1:0]     length;
        logic                 final_flag;
        logic                 error;
    } t_cmd;

endpackage

// ----- src/trrd_front.sv -----
// byte front end: header parse, opcode decode, word count check, command issue
module trrd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_final_byte,
    input  logic                i_full,
    output logic                o_push,
    output trrd_pkg::t_cmd      o_cmd
);

    logic [trrd_pkg::HDR_W-1:0]   r_hdr_idx, n_hdr_idx;
    logic [trrd_pkg::COUNT_W-1:0] r_expected, n_expected;
    logic [trrd_pkg::COUNT_W-1:0] r_emitted, n_emitted;
    trrd_pkg::t_phase             r_phase, n_phase;
    logic [7:0]                   r_opcode, n_opcode;
    logic [7:0]                   r_high, n_high;

    trrd_pkg::t_cmd               cmd;
    logic                         accept;
    logic [7:0]                   run_op;
    logic [trrd_pkg::COUNT_W:0]   sum;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_hdr_idx  = r_hdr_idx;
        n_expected = r_expected;
        n_emitted  = r_emitted;
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_high     = r_high;
        run_op     = r_opcode;

        cmd            = '0;
        cmd.op         = trrd_pkg::OP_NONE;
        cmd.step       = trrd_pkg::STEP_HOLD;
        cmd.src        = r_opcode[5:4];
        cmd.dst        = r_opcode[3:2];
        cmd.final_flag = i_final_byte;

        if (r_hdr_idx < trrd_pkg::HDR_W'(trrd_pkg::HEADER_BYTES)) begin
            case (r_hdr_idx)
                trrd_pkg::HDR_W'(1): n_expected[7:0]   = i_data_byte;
                trrd_pkg::HDR_W'(2): n_expected[15:8]  = i_data_byte;
                trrd_pkg::HDR_W'(3): n_expected[23:16] = i_data_byte;
                default: ;
            endcase
            n_hdr_idx = r_hdr_idx + trrd_pkg::HDR_W'(1);
            if (n_hdr_idx == trrd_pkg::HDR_W'(trrd_pkg::HEADER_BYTES)) begin
                n_expected = n_expected >> 1;
            end
        end else begin
            case (r_phase)
                trrd_pkg::PH_OPCODE: begin
                    n_opcode = i_data_byte;
                    n_high   = 8'h00;
                    run_op   = i_data_byte;
                    cmd.src  = i_data_byte[5:4];
                    cmd.dst  = i_data_byte[3:2];
                    if (i_data_byte[7:6] == trrd_pkg::KIND_XOR) begin
                        if (i_data_byte[1]) begin
                            n_phase = trrd_pkg::PH_HIGH;
                        end else if (i_data_byte[0]) begin
                            n_phase = trrd_pkg::PH_LOW;
                        end else begin
                            cmd.op = trrd_pkg::OP_XOR;
                        end
                    end else if (i_data_byte[3:0] == trrd_pkg::LEN_ESCAPE) begin
                        n_phase = trrd_pkg::PH_LENGTH;
                    end else begin
                        cmd.op     = trrd_pkg::OP_RUN;
                        cmd.length = trrd_pkg::LEN_W'(i_data_byte[3:0]) + trrd_pkg::LEN_W'(1);
                    end
                end
                trrd_pkg::PH_HIGH: begin
                    n_high = i_data_byte;
                    if (r_opcode[0]) begin
                        n_phase = trrd_pkg::PH_LOW;
                    end else begin
                        cmd.op      = trrd_pkg::OP_XOR;
                        cmd.operand = {i_data_byte, 8'h00};
                        n_phase     = trrd_pkg::PH_OPCODE;
                    end
                end
                trrd_pkg::PH_LOW: begin
                    cmd.op      = trrd_pkg::OP_XOR;
                    cmd.operand = {r_high, i_data_byte};
                    n_phase     = trrd_pkg::PH_OPCODE;
                end
                default: begin
                    cmd.op     = trrd_pkg::OP_RUN;
                    cmd.length = trrd_pkg::LEN_W'(i_data_byte)
                               + trrd_pkg::LEN_W'(trrd_pkg::LONG_RUN_BIAS);
                    n_phase    = trrd_pkg::PH_OPCODE;
                end
            endcase
        end

        case (run_op[7:6])
            trrd_pkg::KIND_UP:   cmd.step = trrd_pkg::STEP_UP;
            trrd_pkg::KIND_DOWN: cmd.step = trrd_pkg::STEP_DOWN;
            default:             cmd.step = trrd_pkg::STEP_HOLD;
        endcase

        // saturating emitted count
        sum = {1'b0, r_emitted} + (trrd_pkg::COUNT_W+1)'(cmd.length);
        if (cmd.op == trrd_pkg::OP_RUN) begin
            n_emitted = sum[trrd_pkg::COUNT_W] ? trrd_pkg::COUNT_MAX
                                               : sum[trrd_pkg::COUNT_W-1:0];
        end

        cmd.error = (n_hdr_idx < trrd_pkg::HDR_W'(trrd_pkg::HEADER_BYTES))
                 || (n_phase != trrd_pkg::PH_OPCODE)
                 || (n_emitted != n_expected);
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.op != trrd_pkg::OP_NONE) || i_final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_final_byte)) begin
            r_hdr_idx  <= '0;
            r_expected <= '0;
            r_emitted  <= '0;
            r_phase    <= trrd_pkg::PH_OPCODE;
            r_opcode   <= '0;
            r_high     <= '0;
        end else if (accept) begin
            r_hdr_idx  <= n_hdr_idx;
            r_expected <= n_expected;
            r_emitted  <= n_emitted;
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_high     <= n_high;
        end
    end

endmodule

// ----- src/trrd_queue.sv -----
// short command queue between front end and run engine
module trrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  trrd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output trrd_pkg::t_cmd o_head
);

    trrd_pkg::t_cmd                   r_mem [trrd_pkg::QUEUE_DEPTH];
    logic [trrd_pkg::QUEUE_AW-1:0]    r_wr, r_rd;
    logic [trrd_pkg::QUEUE_CW-1:0]    r_cnt;
    logic                             do_push, do_pop;

    assign o_full  = (r_cnt == trrd_pkg::QUEUE_CW'(trrd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == trrd_pkg::QUEUE_AW'(trrd_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_wr + trrd_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == trrd_pkg::QUEUE_AW'(trrd_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_rd + trrd_pkg::QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + trrd_pkg::QUEUE_CW'(do_push) - trrd_pkg::QUEUE_CW'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");

endmodule

// ----- src/trrd_back.sv -----
// run engine: value registers, xor update, run expansion into word groups
module trrd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  trrd_pkg::t_cmd                      i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [trrd_pkg::WORD_W-1:0]         o_words [trrd_pkg::SLOT_COUNT],
    output logic [trrd_pkg::WCNT_W-1:0]         o_word_count,
    output logic                                o_group_last,
    output logic                                o_stream_end,
    output logic                                o_size_error
);

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [trrd_pkg::WORD_W-1:0]     r_regs [trrd_pkg::REGISTER_COUNT];
    logic [trrd_pkg::WORD_W-1:0]     n_regs [trrd_pkg::REGISTER_COUNT];
    logic [trrd_pkg::REG_IDX_W-1:0]  r_reg, n_reg;
    trrd_pkg::t_step                 r_step, n_step;
    logic [trrd_pkg::LEN_W-1:0]      r_remain, n_remain;
    logic [trrd_pkg::GRP_W-1:0]      r_grp, n_grp;
    logic                            r_final, n_final;
    logic                            r_error, n_error;

    logic                            r_out_valid, n_out_valid;
    logic [trrd_pkg::WORD_W-1:0]     r_words [trrd_pkg::SLOT_COUNT];
    logic [trrd_pkg::WORD_W-1:0]     n_words [trrd_pkg::SLOT_COUNT];
    logic [trrd_pkg::WCNT_W-1:0]     r_cnt, n_cnt;
    logic                            r_last, n_last;
    logic                            r_end, n_end;
    logic                            r_err, n_err;

    logic                            out_free;
    logic [trrd_pkg::REG_IDX_W-1:0]  rd_idx;
    logic [trrd_pkg::WORD_W-1:0]     rd_val;
    logic [trrd_pkg::WCNT_W-1:0]     grp_cnt;
    logic                            emit, run_done, grp_last, run_adv, pop;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        rd_idx   = (r_state == ST_RUN) ? r_reg : i_head.src;
        rd_val   = r_regs[rd_idx];
        run_done = (r_remain <= trrd_pkg::LEN_W'(trrd_pkg::GROUP_WORDS));
        grp_cnt  = run_done ? trrd_pkg::WCNT_W'(r_remain)
                            : trrd_pkg::WCNT_W'(trrd_pkg::GROUP_WORDS);
        emit     = (r_grp < trrd_pkg::GRP_W'(trrd_pkg::MAX_RESULTS));
        grp_last = run_done || (r_grp == trrd_pkg::GRP_W'(trrd_pkg::MAX_RESULTS - 1));
        run_adv  = (r_state == ST_RUN) && (out_free || !emit);
        pop      = (r_state == ST_FETCH) && !i_empty && out_free;

        n_state  = r_state;
        n_regs   = r_regs;
        n_reg    = r_reg;
        n_step   = r_step;
        n_remain = r_remain;
        n_grp    = r_grp;
        n_final  = r_final;
        n_error  = r_error;

        n_out_valid = r_out_valid && !i_ready;
        n_words     = r_words;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_end       = r_end;
        n_err       = r_err;

        if (pop) begin
            case (i_head.op)
                trrd_pkg::OP_XOR: begin
                    n_regs[i_head.dst] = rd_val ^ i_head.operand;
                end
                trrd_pkg::OP_RUN: begin
                    n_reg    = i_head.src;
                    n_step   = i_head.step;
                    n_remain = i_head.length;
                    n_grp    = '0;
                    n_final  = i_head.final_flag;
                    n_error  = i_head.error;
                    n_state  = ST_RUN;
                end
                default: ;
            endcase
            // final transaction with no words: one empty closing result
            if (i_head.op != trrd_pkg::OP_RUN && i_head.final_flag) begin
                n_out_valid = 1'b1;
                for (int k = 0; k < trrd_pkg::SLOT_COUNT; k++) begin
                    n_words[k] = '0;
                end
                n_cnt  = '0;
                n_last = 1'b1;
                n_end  = 1'b1;
                n_err  = i_head.error;
                for (int r = 0; r < trrd_pkg::REGISTER_COUNT; r++) begin
                    n_regs[r] = '0;
                end
            end
        end

        if (run_adv) begin
            if (emit) begin
                n_out_valid = 1'b1;
                for (int k = 0; k < trrd_pkg::SLOT_COUNT; k++) begin
                    if (k < trrd_pkg::GROUP_WORDS && trrd_pkg::WCNT_W'(k) < grp_cnt) begin
                        case (r_step)
                            trrd_pkg::STEP_UP:   n_words[k] = rd_val + trrd_pkg::WORD_W'(k);
                            trrd_pkg::STEP_DOWN: n_words[k] = rd_val - trrd_pkg::WORD_W'(k);
                            default:             n_words[k] = rd_val;
                        endcase
                    end else begin
                        n_words[k] = '0;
                    end
                end
                n_cnt  = grp_cnt;
                n_last = grp_last;
                n_end  = grp_last && r_final;
                n_err  = grp_last && r_final && r_error;
                n_grp  = r_grp + trrd_pkg::GRP_W'(1);
            end
            case (r_step)
                trrd_pkg::STEP_UP:   n_regs[r_reg] = rd_val + trrd_pkg::WORD_W'(grp_cnt);
                trrd_pkg::STEP_DOWN: n_regs[r_reg] = rd_val - trrd_pkg::WORD_W'(grp_cnt);
                default:             n_regs[r_reg] = rd_val;
            endcase
            n_remain = r_remain - trrd_pkg::LEN_W'(grp_cnt);
            if (run_done) begin
                n_state = ST_FETCH;
                if (r_final) begin
                    for (int r = 0; r < trrd_pkg::REGISTER_COUNT; r++) begin
                        n_regs[r] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_out_valid <= 1'b0;
            for (int r = 0; r < trrd_pkg::REGISTER_COUNT; r++) begin
                r_regs[r] <= '0;
            end
            r_remain    <= '0;
            r_grp       <= '0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_regs      <= n_regs;
            r_remain    <= n_remain;
            r_grp       <= n_grp;
            r_final     <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reg   <= n_reg;
        r_step  <= n_step;
        r_error <= n_error;
        r_words <= n_words;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_end   <= n_end;
        r_err   <= n_err;
    end

    assign o_pop        = pop;
    assign o_valid      = r_out_valid;
    assign o_words      = r_words;
    assign o_word_count = r_cnt;
    assign o_group_last = r_last;
    assign o_stream_end = r_end;
    assign o_size_error = r_err;

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_remain != '0))
        else $error("run engine active with no words left");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_end) |-> o_group_last)
        else $error("stream end on a result that is not the last of its byte");

    a_error_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_size_error) |-> o_stream_end)
        else $error("size error outside stream end");

endmodule

// ----- src/tilemap_register_run_decoder_unit.sv -----
// top level of the tilemap register run decoder
//
// input channel: one stream byte per transaction (i_data_byte, i_final_byte),
// handshake i_valid / o_ready. output channel: one group of up to eight
// decoded words per transaction, handshake o_valid / i_ready.
// the front end decodes each accepted byte and queues at most one command
// (xor update, run, or a closing command for a final byte); a two-entry
// queue lets it run ahead of the engine. the run engine emits one group
// per cycle while the receiver is ready; a run is first fetched from the
// queue, then expanded into groups of up to eight words for the output.
// o_ready drops only while the command queue is full, which happens behind
// long runs or a stalled receiver. a stalled receiver holds the output
// register and the engine waits; nothing is dropped.
// the result for a final byte carries stream_end and size_error, after which
// all decoder state returns to its reset values. reset is synchronous,
// active low, and clears header, counters, phase and value registers.
module tilemap_register_run_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_word_0,
    output logic [15:0] o_word_1,
    output logic [15:0] o_word_2,
    output logic [15:0] o_word_3,
    output logic [15:0] o_word_4,
    output logic [15:0] o_word_5,
    output logic [15:0] o_word_6,
    output logic [15:0] o_word_7,
    output logic [3:0]  o_word_count,
    output logic        o_group_last,
    output logic        o_stream_end,
    output logic        o_size_error
);

    trrd_pkg::t_cmd                push_cmd, head_cmd;
    logic                          push, full, pop, empty;
    logic [trrd_pkg::WORD_W-1:0]   words [trrd_pkg::SLOT_COUNT];

    trrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    trrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    trrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_words      (words),
        .o_word_count (o_word_count),
        .o_group_last (o_group_last),
        .o_stream_end (o_stream_end),
        .o_size_error (o_size_error)
    );

    assign o_word_0 = words[0];
    assign o_word_1 = words[1];
    assign o_word_2 = words[2];
    assign o_word_3 = words[3];
    assign o_word_4 = words[4];
    assign o_word_5 = words[5];
    assign o_word_6 = words[6];
    assign o_word_7 = words[7];

endmodule

// ----- tb/tilemap_register_run_decoder_unit_test.sv -----
// testbench for the tilemap register run decoder: directed rows, random streams, scoreboard
module tilemap_register_run_decoder_unit_test;

    typedef struct packed {
        logic [7:0][15:0] words;
        logic [3:0]       count;
        logic             last;
        logic             send;
        logic             err;
    } t_group;

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        typed;
        logic [15:0] w0;
        logic [3:0]  count;
        logic        last;
        logic        send;
        logic        err;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_final_byte = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_word_0, o_word_1, o_word_2, o_word_3;
    logic [15:0] o_word_4, o_word_5, o_word_6, o_word_7;
    logic [3:0]  o_word_count;
    logic        o_group_last;
    logic        o_stream_end;
    logic        o_size_error;

    // decoder state mirror
    logic [15:0]      map_regs [trrd_pkg::REGISTER_COUNT];
    int               hdr_count;
    logic [23:0]      words_promised;
    logic [23:0]      words_made;
    trrd_pkg::t_phase phase_now;
    logic [7:0]       op_latched;
    logic [7:0]       high_latched;
    logic [15:0]      burst_words [$];
    t_group           expected_groups [$];

    int mismatches = 0;
    bit idle_on = 1'b0;
    int stall_left = 0;

    // directed rows: lone final byte, a small clean stream, a long stream ending mid-instruction
    t_stim_row directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, 16'h0000, 4'd0, 1'b1, 1'b1, 1'b1},
        '{8'h10, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h06, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h07, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hD0, 1'b0, 1'b1, 16'hFFFF, 4'd1, 1'b1, 1'b0, 1'b0},
        '{8'h50, 1'b0, 1'b1, 16'h0000, 4'd1, 1'b1, 1'b0, 1'b0},
        '{8'h90, 1'b1, 1'b1, 16'hFFFF, 4'd1, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h4F, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'hAB, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h31, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h3C, 1'b0, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0, 1'b0},
        '{8'h02, 1'b1, 1'b1, 16'h0000, 4'd0, 1'b1, 1'b1, 1'b1}
    };

    tilemap_register_run_decoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_0     (o_word_0),
        .o_word_1     (o_word_1),
        .o_word_2     (o_word_2),
        .o_word_3     (o_word_3),
        .o_word_4     (o_word_4),
        .o_word_5     (o_word_5),
        .o_word_6     (o_word_6),
        .o_word_7     (o_word_7),
        .o_word_count (o_word_count),
        .o_group_last (o_group_last),
        .o_stream_end (o_stream_end),
        .o_size_error (o_size_error)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_decoder();
        for (int k = 0; k < trrd_pkg::REGISTER_COUNT; k++) map_regs[k] = 16'h0000;
        hdr_count = 0;
        words_promised = '0;
        words_made = '0;
        phase_now = trrd_pkg::PH_OPCODE;
        op_latched = 8'h00;
        high_latched = 8'h00;
    endfunction

    function automatic void apply_xor(logic [7:0] low_byte);
        map_regs[op_latched[3:2]] = map_regs[op_latched[5:4]] ^ {high_latched, low_byte};
    endfunction

    function automatic void expand_run(int len);
        logic [15:0] v;
        logic [24:0] total;
        for (int k = 0; k < len; k++) begin
            v = map_regs[op_latched[5:4]];
            burst_words.push_back(v);
            if (op_latched[7:6] == trrd_pkg::KIND_UP)
                map_regs[op_latched[5:4]] = v + 16'd1;
            else if (op_latched[7:6] == trrd_pkg::KIND_DOWN)
                map_regs[op_latched[5:4]] = v - 16'd1;
        end
        total = {1'b0, words_made} + 25'(len);
        words_made = (total > {1'b0, trrd_pkg::COUNT_MAX}) ? trrd_pkg::COUNT_MAX : total[23:0];
    endfunction

    // advance the mirror by one byte and queue the groups it releases
    function automatic void decode_byte(logic [7:0] b, logic fin);
        int     groups;
        int     pos;
        bit     bad;
        t_group g;
        burst_words.delete();
        if (hdr_count < trrd_pkg::HEADER_BYTES) begin
            if (hdr_count >= 1) words_promised = words_promised | (24'(b) << (8 * (hdr_count - 1)));
            hdr_count++;
            if (hdr_count == trrd_pkg::HEADER_BYTES) words_promised = words_promised >> 1;
        end else begin
            case (phase_now)
                trrd_pkg::PH_OPCODE: begin
                    op_latched = b;
                    high_latched = 8'h00;
                    if (b[7:6] == trrd_pkg::KIND_XOR) begin
                        if (b[1]) phase_now = trrd_pkg::PH_HIGH;
                        else if (b[0]) phase_now = trrd_pkg::PH_LOW;
                        else apply_xor(8'h00);
                    end else if (b[3:0] == trrd_pkg::LEN_ESCAPE) begin
                        phase_now = trrd_pkg::PH_LENGTH;
                    end else begin
                        expand_run(int'(b[3:0]) + 1);
                    end
                end
                trrd_pkg::PH_HIGH: begin
                    high_latched = b;
                    if (op_latched[0]) begin
                        phase_now = trrd_pkg::PH_LOW;
                    end else begin
                        apply_xor(8'h00);
                        phase_now = trrd_pkg::PH_OPCODE;
                    end
                end
                trrd_pkg::PH_LOW: begin
                    apply_xor(b);
                    phase_now = trrd_pkg::PH_OPCODE;
                end
                default: begin
                    expand_run(int'(b) + trrd_pkg::LONG_RUN_BIAS);
                    phase_now = trrd_pkg::PH_OPCODE;
                end
            endcase
        end
        bad = (hdr_count < trrd_pkg::HEADER_BYTES) || (phase_now != trrd_pkg::PH_OPCODE) ||
              (words_made != words_promised);
        groups = (burst_words.size() + trrd_pkg::GROUP_WORDS - 1) / trrd_pkg::GROUP_WORDS;
        if (groups > trrd_pkg::MAX_RESULTS) groups = trrd_pkg::MAX_RESULTS;
        if (groups == 0 && fin) groups = 1;
        pos = 0;
        for (int n = 0; n < groups; n++) begin
            g = '0;
            for (int k = 0; k < trrd_pkg::GROUP_WORDS; k++) begin
                if (pos < burst_words.size()) begin
                    g.words[k] = burst_words[pos];
                    g.count = g.count + 4'd1;
                    pos++;
                end
            end
            g.last = (n == groups - 1);
            g.send = g.last && fin;
            g.err = g.last && fin && bad;
            expected_groups.push_back(g);
        end
        if (fin) clear_decoder();
    endfunction

    function automatic void field_check(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic fin, logic typed, t_group typed_want);
        int depth;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_ready);
        depth = expected_groups.size();
        decode_byte(b, fin);
        if (typed) begin
            while (expected_groups.size() > depth) void'(expected_groups.pop_back());
            expected_groups.push_back(typed_want);
        end
    endtask

    // receiver: check each output transaction, stall in random bursts
    always @(posedge i_clk) begin : rx_side
        t_group want;
        t_group got;
        if (i_rst_n && o_valid && i_ready) begin
            got.words = {o_word_7, o_word_6, o_word_5, o_word_4,
                         o_word_3, o_word_2, o_word_1, o_word_0};
            got.count = o_word_count;
            got.last = o_group_last;
            got.send = o_stream_end;
            got.err = o_size_error;
            if (expected_groups.size() == 0) begin
                $display("%0t: unexpected group, expected none, actual count %0d word_0 %h",
                         $time, got.count, got.words[0]);
                mismatches++;
            end else begin
                want = expected_groups.pop_front();
                for (int k = 0; k < 8; k++)
                    field_check($sformatf("word_%0d", k), want.words[k], got.words[k]);
                field_check("word_count", 16'(want.count), 16'(got.count));
                field_check("group_last", 16'(want.last), 16'(got.last));
                field_check("stream_end", 16'(want.send), 16'(got.send));
                field_check("size_error", 16'(want.err), 16'(got.err));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        t_group      typed_want;
        logic [7:0]  body [$];
        logic [7:0]  op;
        logic [23:0] size;
        int          words;
        int          mode;
        int          lenb;
        int          sent;
        clear_decoder();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        foreach (directed_rows[i]) begin
            typed_want = '0;
            typed_want.words[0] = directed_rows[i].w0;
            typed_want.count = directed_rows[i].count;
            typed_want.last = directed_rows[i].last;
            typed_want.send = directed_rows[i].send;
            typed_want.err = directed_rows[i].err;
            send_byte(directed_rows[i].data, directed_rows[i].fin,
                      directed_rows[i].typed, typed_want);
        end

        sent = $size(directed_rows);
        while (sent < 220) begin
            idle_on = (sent < 180) && ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 9);
            body.delete();
            words = 0;
            if (mode == 0) begin
                // noise
                repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    op = 8'($urandom);
                    if (op[7:6] == trrd_pkg::KIND_XOR) begin
                        body.push_back(op);
                        if (op[1]) body.push_back(8'($urandom));
                        if (op[0]) body.push_back(8'($urandom));
                    end else if ($urandom_range(0, 3) == 0) begin
                        op[3:0] = trrd_pkg::LEN_ESCAPE;
                        lenb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 16);
                        body.push_back(op);
                        body.push_back(8'(lenb));
                        words += lenb + trrd_pkg::LONG_RUN_BIAS;
                    end else begin
                        if (op[3:0] == trrd_pkg::LEN_ESCAPE) op[3:0] = 4'($urandom_range(0, 14));
                        body.push_back(op);
                        words += int'(op[3:0]) + 1;
                    end
                end
                size = 24'(2 * words + $urandom_range(0, 1));
                // broken streams: wrong size or cut short
                if (mode == 1) size = 24'($urandom);
                if (mode == 2 && body.size() > 1) void'(body.pop_back());
                body.push_front(size[23:16]);
                body.push_front(size[15:8]);
                body.push_front(size[7:0]);
                body.push_front(8'($urandom));
            end
            foreach (body[i]) begin
                send_byte(body[i], i == body.size() - 1, 1'b0, '0);
                sent++;
            end
        end
        i_valid <= 1'b0;

        while (expected_groups.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tilemap_register_run_decoder_unit_test: clean");
        end else begin
            $display("tilemap_register_run_decoder_unit_test: errors");
        end
        $finish;
    end

    initial begin
        #(8 * 600000);
        $display("tilemap_register_run_decoder_unit_test: errors");
        $finish;
    end

endmodule
